### design/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg: shared types and constants for the sliding window min/max filter
// Sample and length types plus the control bundle that the sequencer hands
// to the cell chain.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int unsigned WinMax  = 256;
  localparam int unsigned SampleW = 32;
  localparam int unsigned LenW    = $clog2(WinMax + 1);
  localparam int unsigned IdxW    = (WinMax > 1) ? $clog2(WinMax) : 1;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic        [LenW-1:0]    len_t;
  typedef logic        [IdxW-1:0]    idx_t;

  // Control from the sequencer to the chain: advance the cells on a sample
  // transfer, and pick the cell whose suffix min/max forms the result.
  typedef struct packed {
    logic shift_en;
    idx_t tap_idx;
  } chain_ctl_t;

endpackage

### design/swmm_in_if.sv
// ----------------------------------------------------------------------------
// swmm_in_if: sample input channel
// Valid/ready channel carrying one signed sample and its end-of-sequence flag.
// ----------------------------------------------------------------------------
interface swmm_in_if;
  logic              valid;
  logic              ready;
  swmm_pkg::sample_t sample;
  logic              last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

### design/swmm_out_if.sv
// ----------------------------------------------------------------------------
// swmm_out_if: result output channel
// Valid/ready channel carrying the window minimum, maximum and final flag.
// ----------------------------------------------------------------------------
interface swmm_out_if;
  logic              valid;
  logic              ready;
  swmm_pkg::sample_t window_min;
  swmm_pkg::sample_t window_max;
  logic              final_result;

  modport source (output valid, output window_min, output window_max,
                  output final_result, input ready);
  modport sink   (input valid, input window_min, input window_max,
                  input final_result, output ready);
endinterface

### design/swmm_cfg_if.sv
// ----------------------------------------------------------------------------
// swmm_cfg_if: configuration write channel
// Valid/ready channel carrying a new window length.
// ----------------------------------------------------------------------------
interface swmm_cfg_if;
  logic           valid;
  logic           ready;
  swmm_pkg::len_t window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

### design/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell: one cell of the suffix min/max chain
// Cell i holds the min and max of the newest i+1 samples. On each sample
// transfer it combines the new sample with its neighbor's previous values.
// ----------------------------------------------------------------------------
module swmm_cell (
  input  logic              clk_i,
  input  logic              shift_en_i,
  input  swmm_pkg::sample_t sample_i,
  input  swmm_pkg::sample_t prev_min_i,
  input  swmm_pkg::sample_t prev_max_i,
  output swmm_pkg::sample_t min_o,
  output swmm_pkg::sample_t max_o
);

  swmm_pkg::sample_t min_q, min_d;
  swmm_pkg::sample_t max_q, max_d;

  always_comb begin
    min_d = (prev_min_i < sample_i) ? prev_min_i : sample_i;
    max_d = (prev_max_i > sample_i) ? prev_max_i : sample_i;
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign min_o = min_q;
  assign max_o = max_q;

endmodule

### design/swmm_ctrl.sv
// ----------------------------------------------------------------------------
// swmm_ctrl: sequence counter, window register and result pipeline
// Counts samples of the current sequence, decides which transfers yield a
// result and which chain cell holds it, and drives the output register.
// ----------------------------------------------------------------------------
module swmm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  input  swmm_pkg::len_t       cfg_len_i,
  // sample channel handshake
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  // chain control and tap data
  output swmm_pkg::chain_ctl_t ctl_o,
  input  swmm_pkg::sample_t    tap_min_i,
  input  swmm_pkg::sample_t    tap_max_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output swmm_pkg::sample_t    out_min_o,
  output swmm_pkg::sample_t    out_max_o,
  output logic                 out_final_o
);

  localparam swmm_pkg::len_t LenMax = swmm_pkg::LenW'(swmm_pkg::WinMax);
  localparam swmm_pkg::len_t LenOne = swmm_pkg::LenW'(1);

  swmm_pkg::len_t wlen_q, wlen_d;
  swmm_pkg::len_t seen_q, seen_d;
  logic           pend_v_q, pend_v_d;
  swmm_pkg::idx_t pend_idx_q;
  logic           pend_last_q;
  logic           out_v_q, out_v_d;
  swmm_pkg::sample_t out_min_q, out_max_q;
  logic           out_final_q;

  logic           accept;
  logic           move;
  logic           full;
  logic           has_res;
  swmm_pkg::len_t seen_inc;
  swmm_pkg::len_t span;

  // Window length writes clamp into 1..WinMax.
  always_comb begin
    if (cfg_len_i == '0) begin
      wlen_d = LenOne;
    end else if (cfg_len_i > LenMax) begin
      wlen_d = LenMax;
    end else begin
      wlen_d = cfg_len_i;
    end
  end

  assign move       = pend_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !pend_v_q || !out_v_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    seen_inc = (seen_q == LenMax) ? seen_q : seen_q + LenOne;
    full     = (seen_inc >= wlen_q);
    has_res  = full || in_last_i;
    span     = full ? wlen_q : seen_inc;
    seen_d   = seen_q;
    if (accept) begin
      seen_d = in_last_i ? '0 : seen_inc;
    end
    pend_v_d = (accept && has_res) || (pend_v_q && !move);
    out_v_d  = move || (out_v_q && !out_ready_i);
  end

  // The tap is read after the sample transfer has been registered, once the
  // chain holds the suffix values that include the new sample.
  assign ctl_o.shift_en = accept;
  assign ctl_o.tap_idx  = pend_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q   <= LenOne;
      seen_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        wlen_q <= wlen_d;
      end
      seen_q   <= seen_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_idx_q  <= swmm_pkg::IdxW'(span - LenOne);
      pend_last_q <= in_last_i;
    end
    if (move) begin
      out_min_q   <= tap_min_i;
      out_max_q   <= tap_max_i;
      out_final_q <= pend_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_min_o   = out_min_q;
  assign out_max_o   = out_max_q;
  assign out_final_o = out_final_q;

endmodule

### design/sliding_window_min_max_core.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_core: sliding window minimum/maximum filter
// Streams signed samples and reports the min and max of the newest samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i carries one signed sample per transfer and a last_sample flag
//   that closes a sequence. Once window_len samples of the sequence have
//   arrived, each sample yields one transfer on result_o with the min and
//   max of the newest window_len samples. A last sample that arrives before
//   the window fills yields one result over all samples seen so far. The
//   final_result flag marks the result of the last sample, and the sample
//   count then restarts for the next sequence.
//   cfg_i writes window_len (values clamp into 1..256); write it while idle.
//   The block takes one sample per clock while result_o keeps up. A sample
//   transfer updates the cell chain and registers the tap index; the
//   selected chain tap is then loaded into the output register, which
//   offers the result on result_o.
//   When result_o stalls, samples keep flowing until one more result waits
//   at the chain tap; sample_i.ready then drops until the output register
//   is emptied.
//   Reset clears the sample count and sets window_len to 1; no clearing pass
//   is needed, since only cells written in the current sequence are read.
// ----------------------------------------------------------------------------
module sliding_window_min_max_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  swmm_cfg_if.sink   cfg_i,
  swmm_in_if.sink    sample_i,
  swmm_out_if.source result_o
);

  swmm_pkg::chain_ctl_t ctl;
  swmm_pkg::sample_t    cell_min [swmm_pkg::WinMax];
  swmm_pkg::sample_t    cell_max [swmm_pkg::WinMax];
  swmm_pkg::sample_t    tap_min;
  swmm_pkg::sample_t    tap_max;

  assign cfg_i.ready = 1'b1;

  swmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_len_i   (cfg_i.window_len),
    .in_valid_i  (sample_i.valid),
    .in_last_i   (sample_i.last_sample),
    .in_ready_o  (sample_i.ready),
    .ctl_o       (ctl),
    .tap_min_i   (tap_min),
    .tap_max_i   (tap_max),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_min_o   (result_o.window_min),
    .out_max_o   (result_o.window_max),
    .out_final_o (result_o.final_result)
  );

  // Cell 0 holds the newest sample alone; each later cell extends its
  // neighbor's suffix by one older sample.
  for (genvar i = 0; i < swmm_pkg::WinMax; i++) begin : g_cell
    if (i == 0) begin : g_head
      swmm_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (ctl.shift_en),
        .sample_i   (sample_i.sample),
        .prev_min_i (sample_i.sample),
        .prev_max_i (sample_i.sample),
        .min_o      (cell_min[i]),
        .max_o      (cell_max[i])
      );
    end else begin : g_body
      swmm_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (ctl.shift_en),
        .sample_i   (sample_i.sample),
        .prev_min_i (cell_min[i-1]),
        .prev_max_i (cell_max[i-1]),
        .min_o      (cell_min[i]),
        .max_o      (cell_max[i])
      );
    end
  end

  assign tap_min = cell_min[ctl.tap_idx];
  assign tap_max = cell_max[ctl.tap_idx];

endmodule

### design/swmm_checker.sv
// ----------------------------------------------------------------------------
// swmm_checker: port-level checks for the sliding window min/max filter
// Watches the top level's channels and is bound to every instance of it.
// ----------------------------------------------------------------------------
module swmm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input swmm_pkg::sample_t out_min,
  input swmm_pkg::sample_t out_max,
  input logic              out_final
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // A result that is offered stays offered until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // The minimum of a window never exceeds its maximum.
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_min <= out_max))
    else $error("window minimum above window maximum");

  // A last sample taken while no result is offered closes its sequence with
  // a final result when the output side keeps up.
  a_final_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_last && !out_valid) ##1 out_ready |=> out_valid && out_final)
    else $error("last sample did not produce a final result");

endmodule

bind sliding_window_min_max_core swmm_checker u_swmm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (sample_i.valid),
  .in_ready  (sample_i.ready),
  .in_last   (sample_i.last_sample),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_min   (result_o.window_min),
  .out_max   (result_o.window_max),
  .out_final (result_o.final_result)
);

### dv/tb_sliding_window_min_max_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_min_max_core: self-checking bench for the window filter
// Drives signed samples through the input channel, predicts the window
// minimum and maximum of every sample transfer that yields a result, and
// compares each result transfer against the oldest prediction. A directed
// table opens the run; random sequences over several window lengths and idle patterns follow.
// ----------------------------------------------------------------------------
module tb_sliding_window_min_max_core;

  localparam int                CycleLimit = 200000;
  localparam int                DrainPause = 8;
  localparam swmm_pkg::sample_t SampleTop  = 32'h7FFFFFFF;
  localparam swmm_pkg::sample_t SampleBot  = 32'h80000000;

  typedef enum logic {RowSample, RowCfg} row_kind_e;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct packed {
    swmm_pkg::sample_t lo;
    swmm_pkg::sample_t hi;
    logic              fin;
  } window_res_t;

  typedef struct packed {
    row_kind_e         kind;
    logic [31:0]       data;
    logic              last;
    logic              typed;
    swmm_pkg::sample_t exp_min;
    swmm_pkg::sample_t exp_max;
    logic              exp_fin;
  } row_t;

  // Window length starts at 1 after reset.
  localparam row_t Plan [26] = '{
    '{RowSample, 32'h7FFFFFFF, 1'b0, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0},
    '{RowSample, 32'h80000000, 1'b0, 1'b1, 32'h80000000, 32'h80000000, 1'b0},
    '{RowSample, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1},
    '{RowCfg,    32'd0,        1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'd5,        1'b0, 1'b1, 32'd5,        32'd5,        1'b0},
    '{RowCfg,    32'd4,        1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'd1,        1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'h80000000, 1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'h7FFFFFFF, 1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'd3,        1'b0, 1'b1, 32'h80000000, 32'h7FFFFFFF, 1'b0},
    '{RowSample, 32'd2,        1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'd9,        1'b1, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'd10,       1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'hFFFFFFF6, 1'b1, 1'b1, 32'hFFFFFFF6, 32'd10,       1'b1},
    '{RowSample, 32'd7,        1'b1, 1'b1, 32'd7,        32'd7,        1'b1},
    '{RowSample, 32'd1,        1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'd2,        1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowCfg,    32'd3,        1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'd3,        1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowCfg,    32'd6,        1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'd4,        1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'd5,        1'b1, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowCfg,    32'h1FF,      1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'h80000000, 1'b1, 1'b1, 32'h80000000, 32'h80000000, 1'b1},
    '{RowCfg,    32'd256,      1'b0, 1'b0, 32'd0,        32'd0,        1'b0},
    '{RowSample, 32'd0,        1'b1, 1'b1, 32'd0,        32'd0,        1'b1}
  };

  // Window lengths written ahead of each random phase; one phase draws its own.
  localparam int WinPlan [10] = '{2, 3, 1, 511, 5, 0, 16, 256, 0, 8};
  localparam int RandomWinPhase = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  swmm_cfg_if cfg_if ();
  swmm_in_if  in_if ();
  swmm_out_if out_if ();

  sliding_window_min_max_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_if),
    .sample_i(in_if),
    .result_o(out_if)
  );

  always #10 clk_i = ~clk_i;

  window_res_t       pending_windows [$];
  swmm_pkg::sample_t seq_hist [$];
  int                seq_seen;
  int                win_len;
  int                err_count;
  int                cycle_count;
  int                send_idle_pct;
  int                recv_stall_pct;

  // Newest sample sits at the front of the history, as in the cell chain.
  function automatic void predict_window(input swmm_pkg::sample_t s, input logic lst,
                                         output logic hit, output window_res_t r);
    int span;
    hit = 1'b0;
    r   = '0;
    seq_hist.push_front(s);
    if (seq_hist.size() > swmm_pkg::WinMax) void'(seq_hist.pop_back());
    if (seq_seen < swmm_pkg::WinMax) seq_seen++;
    if (seq_seen >= win_len) begin
      span = win_len;
    end else if (lst) begin
      span = seq_seen;
    end else begin
      return;
    end
    r.lo = seq_hist[0];
    r.hi = seq_hist[0];
    for (int i = 1; i < span; i++) begin
      if ($signed(seq_hist[i]) < $signed(r.lo)) r.lo = seq_hist[i];
      if ($signed(seq_hist[i]) > $signed(r.hi)) r.hi = seq_hist[i];
    end
    r.fin = lst;
    hit   = 1'b1;
    if (lst) seq_seen = 0;
  endfunction

  function automatic swmm_pkg::sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return SampleTop;
      1:       return SampleBot;
      2, 3, 4: return swmm_pkg::sample_t'($signed($urandom_range(0, 16)) - 8);
      default: return swmm_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic void set_idle(input idle_mode_e mode);
    case (mode)
      IdleSender:   begin send_idle_pct = 60; recv_stall_pct = 0;  end
      IdleReceiver: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      IdleBoth:     begin send_idle_pct = 27; recv_stall_pct = 27; end
      default:      begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so back-to-back samples follow without a gap in valid.
  task automatic push_sample(input swmm_pkg::sample_t s, input logic lst,
                             input logic typed, input window_res_t typed_res);
    logic        hit;
    window_res_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s;
    in_if.last_sample <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    predict_window(s, lst, hit, r);
    if (hit) pending_windows.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  // The length register only changes once the filter has drained; samples
  // that produce no result may still be in the chain, hence the pause.
  task automatic load_window(input swmm_pkg::len_t raw);
    in_if.valid <= 1'b0;
    while (pending_windows.size() != 0) @(negedge clk_i);
    repeat (DrainPause) @(negedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.window_len <= raw;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (raw == 0) win_len = 1;
    else if (raw > swmm_pkg::WinMax) win_len = swmm_pkg::WinMax;
    else win_len = raw;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    window_res_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_windows.size() == 0) begin
        $error("result transfer with no expected window: min %0d max %0d final %0b",
               out_if.window_min, out_if.window_max, out_if.final_result);
        err_count++;
      end else begin
        want = pending_windows.pop_front();
        if (out_if.window_min !== want.lo) begin
          $error("window_min: expected %0d, got %0d", want.lo, out_if.window_min);
          err_count++;
        end
        if (out_if.window_max !== want.hi) begin
          $error("window_max: expected %0d, got %0d", want.hi, out_if.window_max);
          err_count++;
        end
        if (out_if.final_result !== want.fin) begin
          $error("final_result: expected %0b, got %0b", want.fin, out_if.final_result);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    window_res_t no_res;
    window_res_t row_res;
    int          target;
    int          fed;
    int          seq_len;
    logic        lst;

    no_res            = '0;
    seq_seen          = 0;
    win_len           = 1;
    set_idle(IdleNone);
    rst_ni            = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.window_len = '0;
    in_if.valid       = 1'b0;
    in_if.sample      = '0;
    in_if.last_sample = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (Plan[k]) begin
      if (Plan[k].kind == RowCfg) begin
        load_window(Plan[k].data[swmm_pkg::LenW-1:0]);
      end else begin
        row_res = '{lo: Plan[k].exp_min, hi: Plan[k].exp_max, fin: Plan[k].exp_fin};
        push_sample(swmm_pkg::sample_t'(Plan[k].data), Plan[k].last, Plan[k].typed,
                    row_res);
      end
    end

    for (int p = 0; p < $size(WinPlan); p++) begin
      set_idle(idle_mode_e'(p % 4));
      load_window((p == RandomWinPhase) ? swmm_pkg::len_t'($urandom_range(0, 511))
                                        : swmm_pkg::len_t'(WinPlan[p]));
      target = (win_len >= 200) ? 200 : 40;
      fed    = 0;
      while (fed < target) begin
        if (win_len >= 200) seq_len = $urandom_range(win_len + 1, win_len + 40);
        else if ($urandom_range(0, 3) == 0) seq_len = $urandom_range(1, win_len);
        else seq_len = $urandom_range(win_len, 3 * win_len + 8);
        for (int i = 0; i < seq_len; i++) begin
          lst = (i == seq_len - 1);
          // Sometimes the sequence stays open so the next length applies mid-way.
          if (lst && fed + 1 >= target && $urandom_range(0, 2) == 0) lst = 1'b0;
          push_sample(rand_sample(), lst, 1'b0, no_res);
          fed++;
        end
      end
    end

    in_if.valid <= 1'b0;
    while (pending_windows.size() != 0) @(negedge clk_i);
    repeat (DrainPause) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
